// File: sv/ftbg_pkg.sv
`default_nettype none

package ftbg_pkg;

    localparam int unsigned TGT_W   = 30;
    localparam int unsigned ACT_W   = 32;
    localparam int unsigned THR_W   = TGT_W + 1;
    localparam int unsigned MULT_W  = 7;
    localparam int unsigned QUO_W   = 24;
    localparam int unsigned REM_W   = 7;
    localparam int unsigned HI_W    = QUO_W + MULT_W;
    localparam int unsigned LO_W    = REM_W + MULT_W;
    localparam int unsigned JOB_W   = 3;

    // x / 100 for x below 2^30: (x * RECIP_100) >> RCP_SH
    localparam int unsigned RCP_W       = 31;
    localparam int unsigned RCP_PROD_W  = TGT_W + RCP_W;
    localparam int unsigned RCP_SH      = 37;
    // y / 100 for y below 2^14: (y * RECIP_100_LO) >> RCP_LO_SH
    localparam int unsigned RCP_LO_W    = 15;
    localparam int unsigned FRAC_PROD_W = LO_W + RCP_LO_W;
    localparam int unsigned RCP_LO_SH   = 21;

    localparam logic [TGT_W-1:0] RESET_TARGET_NS = TGT_W'(16666667);
    localparam logic [TGT_W-1:0] FLOOR_NS        = TGT_W'(8000000);
    localparam logic [6:0]       RECOVERY_LEN    = 7'd120;
    localparam logic [1:0]       MISS_LIMIT      = 2'd3;
    localparam logic [1:0]       BOOST_MAX       = 2'd3;
    localparam logic [REM_W:0]   DIVISOR         = 8'd100;
    localparam logic [RCP_W-1:0]    RECIP_100    = 31'd1374389535;
    localparam logic [RCP_LO_W-1:0] RECIP_100_LO = 15'd20972;

    localparam logic [JOB_W-1:0] JOB_MISS  = 3'd0;
    localparam logic [JOB_W-1:0] JOB_COMFY = 3'd1;
    localparam logic [JOB_W-1:0] JOB_EFF1  = 3'd2;
    localparam logic [JOB_W-1:0] JOB_EFF2  = 3'd3;
    localparam logic [JOB_W-1:0] JOB_EFF3  = 3'd4;

    localparam longint unsigned RST_T  = 64'd16666667;
    localparam longint unsigned RST_FL = 64'd8000000;
    localparam longint unsigned RST_Q1 = RST_T * 92 / 100;
    localparam longint unsigned RST_Q2 = RST_T * 85 / 100;
    localparam longint unsigned RST_Q3 = RST_T * 78 / 100;
    localparam logic [TGT_W-1:0] RST_EFF0 = TGT_W'((RST_T  < RST_FL) ? RST_FL : RST_T);
    localparam logic [TGT_W-1:0] RST_EFF1 = TGT_W'((RST_Q1 < RST_FL) ? RST_FL : RST_Q1);
    localparam logic [TGT_W-1:0] RST_EFF2 = TGT_W'((RST_Q2 < RST_FL) ? RST_FL : RST_Q2);
    localparam logic [TGT_W-1:0] RST_EFF3 = TGT_W'((RST_Q3 < RST_FL) ? RST_FL : RST_Q3);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_REM,
        ST_PROD,
        ST_STORE,
        ST_FIN
    } t_state;

    typedef struct packed {
        logic [TGT_W-1:0]            req;
        logic [THR_W-1:0]            thr_miss;
        logic [THR_W-1:0]            thr_severe;
        logic [TGT_W-1:0]            thr_comfy;
        logic [3:0][TGT_W-1:0]       eff;
    } t_limits;

    typedef struct packed {
        logic busy;
        logic done;
    } t_calc_stat;

    localparam t_limits RESET_LIMITS = '{
        req:        RESET_TARGET_NS,
        thr_miss:   THR_W'(RST_T + RST_T / 20),
        thr_severe: THR_W'(RST_T + RST_T / 2),
        thr_comfy:  TGT_W'(RST_T * 9 / 10),
        eff:        {RST_EFF3, RST_EFF2, RST_EFF1, RST_EFF0}
    };

    function automatic logic [MULT_W-1:0] f_job_mult(input logic [JOB_W-1:0] job);
        logic [MULT_W-1:0] m;
        case (job)
            JOB_MISS:  m = 7'd5;
            JOB_COMFY: m = 7'd90;
            JOB_EFF1:  m = 7'd92;
            JOB_EFF2:  m = 7'd85;
            JOB_EFF3:  m = 7'd78;
            default:   m = 7'd0;
        endcase
        return m;
    endfunction

    function automatic logic [TGT_W-1:0] f_floor(input logic [TGT_W-1:0] v);
        return (v < FLOOR_NS) ? FLOOR_NS : v;
    endfunction

endpackage

`default_nettype wire

// File: sv/ftbg_calc.sv
`default_nettype none

module ftbg_calc import ftbg_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [TGT_W-1:0] i_req,
    output t_calc_stat       o_stat,
    output t_limits          o_lim
);

    t_state             r_state, n_state;
    t_limits            r_lim,   n_lim;
    logic [JOB_W-1:0]   r_job,   n_job;
    logic [QUO_W-1:0]   r_quo,   n_quo;
    logic [REM_W-1:0]   r_rem,   n_rem;
    logic [TGT_W-1:0]   r_hi,    n_hi;
    logic [LO_W-1:0]    r_lo,    n_lo;

    logic [MULT_W-1:0]      w_mult;
    logic [RCP_PROD_W-1:0]  w_recip;
    logic [TGT_W-1:0]       w_qx100;
    logic [TGT_W-1:0]       w_rem_full;
    logic [HI_W-1:0]        w_hi;
    logic [LO_W-1:0]        w_lo;
    logic [FRAC_PROD_W-1:0] w_frac_prod;
    logic [REM_W-1:0]       w_frac;
    logic [TGT_W-1:0]       w_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_lim   <= RESET_LIMITS;
            r_job   <= JOB_MISS;
        end else begin
            r_state <= n_state;
            r_lim   <= n_lim;
            r_job   <= n_job;
        end
    end

    always_ff @(posedge i_clk) begin
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_hi  <= n_hi;
        r_lo  <= n_lo;
    end

    // req = 100 q + r, quotient by reciprocal multiply
    assign w_recip    = RCP_PROD_W'(r_lim.req) * RCP_PROD_W'(RECIP_100);
    assign w_qx100    = TGT_W'(r_quo) * TGT_W'(DIVISOR);
    assign w_rem_full = r_lim.req - w_qx100;

    // req * m / 100 = q * m + (r * m) / 100
    assign w_mult      = f_job_mult(r_job);
    assign w_hi        = HI_W'(r_quo) * HI_W'(w_mult);
    assign w_lo        = LO_W'(r_rem) * LO_W'(w_mult);
    assign w_frac_prod = FRAC_PROD_W'(r_lo) * FRAC_PROD_W'(RECIP_100_LO);
    assign w_frac      = w_frac_prod[RCP_LO_SH +: REM_W];
    assign w_sum       = r_hi + TGT_W'(w_frac);

    always_comb begin
        n_state = r_state;
        n_lim   = r_lim;
        n_job   = r_job;
        n_quo   = r_quo;
        n_rem   = r_rem;
        n_hi    = r_hi;
        n_lo    = r_lo;
        o_stat.busy = (r_state != ST_IDLE);
        o_stat.done = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_lim.req        = i_req;
                    n_lim.thr_severe = {1'b0, i_req} + {2'b00, i_req[TGT_W-1:1]};
                    n_lim.eff[0]     = f_floor(i_req);
                    n_job            = JOB_MISS;
                    n_state          = ST_LOAD;
                end
            end
            ST_LOAD: begin
                n_quo   = w_recip[RCP_SH +: QUO_W];
                n_state = ST_REM;
            end
            ST_REM: begin
                n_rem   = w_rem_full[REM_W-1:0];
                n_state = ST_PROD;
            end
            ST_PROD: begin
                n_hi    = w_hi[TGT_W-1:0];
                n_lo    = w_lo;
                n_state = ST_STORE;
            end
            ST_STORE: begin
                case (r_job)
                    JOB_MISS:  n_lim.thr_miss  = {1'b0, r_lim.req} + {1'b0, w_sum};
                    JOB_COMFY: n_lim.thr_comfy = w_sum;
                    JOB_EFF1:  n_lim.eff[1]    = f_floor(w_sum);
                    JOB_EFF2:  n_lim.eff[2]    = f_floor(w_sum);
                    JOB_EFF3:  n_lim.eff[3]    = f_floor(w_sum);
                    default:   n_lim = r_lim;
                endcase
                if (r_job == JOB_EFF3) begin
                    n_state = ST_FIN;
                end else begin
                    n_job   = r_job + 1'b1;
                    n_state = ST_PROD;
                end
            end
            ST_FIN: begin
                o_stat.done = 1'b1;
                n_state     = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_lim = r_lim;

endmodule

`default_nettype wire

// File: sv/frame_time_boost_governor.sv
// a frame beat is held in an input register and its result beat in an output register
// throughput: one frame beat per cycle, stalls on output backpressure and while targets are rebuilt
// a target write that changes the target holds off input while
// the reciprocal divide-by-100 unit rebuilds five thresholds and targets
// reset: synchronous active-low, target 16666667 ns, boost and counters cleared
`default_nettype none

module frame_time_boost_governor import ftbg_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [TGT_W-1:0] i_requested_target_ns,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [ACT_W-1:0] i_actual_ns,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [TGT_W-1:0] o_effective_target_ns,
    output logic [1:0]       o_boost_out,
    output logic [ACT_W-1:0] o_clamped_actual_ns,
    output logic             o_target_changed
);

    t_limits          w_lim;
    t_calc_stat       w_stat;
    logic             w_start;

    logic             r_in_vld;
    logic [ACT_W-1:0] r_actual;
    logic             r_out_vld;
    logic [TGT_W-1:0] r_eff_out;
    logic [1:0]       r_boost_out;
    logic [ACT_W-1:0] r_clamp_out;
    logic             r_chg_out;

    logic [1:0]       r_boost, n_boost;
    logic [1:0]       r_miss,  n_miss;
    logic [6:0]       r_rec,   n_rec;
    logic [TGT_W-1:0] r_last_eff;

    logic             w_move;
    logic             w_in_fire;
    logic [ACT_W-1:0] w_ceil;
    logic [ACT_W-1:0] w_clamp;
    logic             w_missed;
    logic             w_severe;
    logic             w_comfy;
    logic [1:0]       w_miss_inc;
    logic [6:0]       w_rec_inc;
    logic [TGT_W-1:0] w_eff;

    assign o_cfg_ready = !w_stat.busy;
    assign w_start     = i_cfg_valid && o_cfg_ready && (i_requested_target_ns != '0)
                         && (i_requested_target_ns != w_lim.req);

    ftbg_calc u_calc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_req   (i_requested_target_ns),
        .o_stat  (w_stat),
        .o_lim   (w_lim)
    );

    assign w_move    = r_in_vld && (!r_out_vld || i_ready);
    assign o_ready   = !w_stat.busy && (!r_in_vld || w_move);
    assign w_in_fire = i_valid && o_ready;

    assign w_ceil     = {w_lim.req, 2'b00};
    assign w_clamp    = (r_actual < w_ceil) ? r_actual : w_ceil;
    assign w_missed   = w_clamp > {1'b0, w_lim.thr_miss};
    assign w_severe   = w_clamp > {1'b0, w_lim.thr_severe};
    assign w_comfy    = w_clamp < {2'b00, w_lim.thr_comfy};
    assign w_miss_inc = r_miss + 2'd1;
    assign w_rec_inc  = r_rec + 7'd1;

    always_comb begin
        n_boost = r_boost;
        n_miss  = r_miss;
        n_rec   = r_rec;
        if (w_missed) begin
            n_rec = '0;
            if (w_severe || (w_miss_inc >= MISS_LIMIT)) begin
                if (r_boost != BOOST_MAX) begin
                    n_boost = r_boost + 2'd1;
                end
                n_miss = '0;
            end else begin
                n_miss = w_miss_inc;
            end
        end else begin
            n_miss = '0;
            if (w_comfy && (r_boost != 2'd0)) begin
                if (w_rec_inc >= RECOVERY_LEN) begin
                    n_boost = r_boost - 2'd1;
                    n_rec   = '0;
                end else begin
                    n_rec = w_rec_inc;
                end
            end else begin
                n_rec = '0;
            end
        end
    end

    assign w_eff = w_lim.eff[n_boost];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld   <= 1'b0;
            r_out_vld  <= 1'b0;
            r_boost    <= '0;
            r_miss     <= '0;
            r_rec      <= '0;
            r_last_eff <= RESET_TARGET_NS;
        end else begin
            if (w_in_fire) begin
                r_in_vld <= 1'b1;
            end else if (w_move) begin
                r_in_vld <= 1'b0;
            end
            if (w_move) begin
                r_out_vld <= 1'b1;
            end else if (i_ready) begin
                r_out_vld <= 1'b0;
            end
            if (w_stat.done) begin
                r_last_eff <= w_lim.eff[r_boost];
            end else if (w_move && (r_actual != '0)) begin
                r_boost    <= n_boost;
                r_miss     <= n_miss;
                r_rec      <= n_rec;
                r_last_eff <= w_eff;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_actual <= i_actual_ns;
        end
        if (w_move) begin
            if (r_actual == '0) begin
                r_eff_out   <= r_last_eff;
                r_boost_out <= r_boost;
                r_clamp_out <= '0;
                r_chg_out   <= 1'b0;
            end else begin
                r_eff_out   <= w_eff;
                r_boost_out <= n_boost;
                r_clamp_out <= w_clamp;
                r_chg_out   <= (w_eff != r_last_eff);
            end
        end
    end

    assign o_valid               = r_out_vld;
    assign o_effective_target_ns = r_eff_out;
    assign o_boost_out           = r_boost_out;
    assign o_clamped_actual_ns   = r_clamp_out;
    assign o_target_changed      = r_chg_out;

endmodule

`default_nettype wire

// File: sv/ftbg_checker.sv
`default_nettype none

module ftbg_checker import ftbg_pkg::*; (
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             i_cfg_valid,
    input wire logic             o_cfg_ready,
    input wire logic [TGT_W-1:0] i_requested_target_ns,
    input wire logic             i_valid,
    input wire logic             o_ready,
    input wire logic [ACT_W-1:0] i_actual_ns,
    input wire logic             o_valid,
    input wire logic             i_ready,
    input wire logic [TGT_W-1:0] o_effective_target_ns,
    input wire logic [1:0]       o_boost_out,
    input wire logic [ACT_W-1:0] o_clamped_actual_ns,
    input wire logic             o_target_changed
);

    // stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_effective_target_ns)
            && $stable(o_boost_out) && $stable(o_clamped_actual_ns)
            && $stable(o_target_changed))
        else $error("result beat changed while stalled");

    a_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_effective_target_ns >= FLOOR_NS)
        else $error("effective target below floor");

    // zero-duration beat never flags a change
    a_zero_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_clamped_actual_ns == '0) |-> !o_target_changed)
        else $error("zero-duration beat flagged a change");

    // while the target is being rebuilt no frame beat is taken
    a_busy_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_cfg_ready |-> !o_ready)
        else $error("frame beat taken during target rebuild");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && o_cfg_ready)
        else $error("output not empty after reset");

endmodule

bind frame_time_boost_governor ftbg_checker u_ftbg_checker (.*);

`default_nettype wire
